>>> hw/rtl/vpg_pkg.sv
// Package for the video pixel generator: opcodes, register indices, modes, states, command and status structs.
// No dependencies.
package vpg_pkg;
	localparam int MEM_WORDS = 65536;
	localparam int AW = $clog2(MEM_WORDS);

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_RENDER = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_BORDER = 2'd3;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_BPBASE = 3'd1;
	localparam logic [2:0] REG_ATBASE = 3'd2;
	localparam logic [2:0] REG_PLBASE = 3'd3;
	localparam logic [2:0] REG_FNBASE = 3'd4;
	localparam logic [2:0] REG_BORDER = 3'd5;
	localparam logic [2:0] REG_BLINK  = 3'd6;

	localparam logic [2:0] MODE_BMP4X8 = 3'd0;
	localparam logic [2:0] MODE_BMP8X8 = 3'd1;
	localparam logic [2:0] MODE_BMP8X2 = 3'd2;
	localparam logic [2:0] MODE_BMP2C  = 3'd3;
	localparam logic [2:0] MODE_TEXT4  = 3'd4;
	localparam logic [2:0] MODE_TEXT8  = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ATTR, ST_CHAR, ST_FG, ST_BG, ST_BITS, ST_PAL, ST_OUT
	} state_t;

	// memory read selection issued by the controller
	typedef enum logic [2:0] {
		RD_ATTR, RD_CHAR, RD_FG, RD_BG, RD_BITS, RD_BORDER
	} rdsel_t;

	typedef struct packed {
		logic   load;     // capture input item
		logic   wr;       // memory write
		logic   tick;     // advance blink counter
		logic   rd;       // issue read
		rdsel_t sel;
		logic   lat_attr; // latch data of the previous read
		logic   lat_char;
		logic   lat_fg;
		logic   lat_bg;
		logic   lat_bits;
		logic   lat_pal;  // border colour into fg
		logic   out_set;  // load output register
	} cmd_t;

	typedef struct packed {
		logic op_valid;   // drawing enabled
		logic text;
	} sts_t;
endpackage

>>> hw/rtl/vpg_ctrl.sv
// Controller state machine of the video pixel generator.
// Depends on vpg_pkg.
module vpg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic [1:0]      opcode,
	input  logic            out_busy,
	input  vpg_pkg::sts_t   sts,
	output logic            idle,
	output vpg_pkg::cmd_t   cmd
);
	vpg_pkg::state_t state_q, state_n;
	logic border_q, border_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vpg_pkg::ST_IDLE;
			border_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			border_q <= border_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		border_n = border_q;
		cmd      = '0;
		cmd.sel  = vpg_pkg::RD_ATTR;
		idle     = 1'b0;
		unique case (state_q)
			vpg_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					unique case (opcode)
						vpg_pkg::OP_WRITE:  cmd.wr = 1'b1;
						vpg_pkg::OP_TICK:   cmd.tick = 1'b1;
						vpg_pkg::OP_BORDER: begin
							border_n = 1'b1;
							state_n  = vpg_pkg::ST_ATTR;
						end
						default: begin
							border_n = 1'b0;
							state_n  = vpg_pkg::ST_ATTR;
						end
					endcase
				end
			end
			vpg_pkg::ST_ATTR: begin
				cmd.rd = 1'b1;
				if (border_q) begin
					cmd.sel = vpg_pkg::RD_BORDER;
					state_n = vpg_pkg::ST_PAL;
				end else if (!sts.op_valid) begin
					cmd.rd  = 1'b0;
					state_n = vpg_pkg::ST_OUT;
				end else begin
					cmd.sel = sts.text ? vpg_pkg::RD_CHAR : vpg_pkg::RD_ATTR;
					state_n = sts.text ? vpg_pkg::ST_CHAR : vpg_pkg::ST_FG;
				end
			end
			vpg_pkg::ST_CHAR: begin
				// char word returns, now attribute
				cmd.lat_char = 1'b1;
				cmd.rd       = 1'b1;
				cmd.sel      = vpg_pkg::RD_ATTR;
				state_n      = vpg_pkg::ST_FG;
			end
			vpg_pkg::ST_FG: begin
				cmd.lat_attr = 1'b1;
				cmd.rd       = 1'b1;
				cmd.sel      = vpg_pkg::RD_FG;
				state_n      = vpg_pkg::ST_BG;
			end
			vpg_pkg::ST_BG: begin
				cmd.lat_fg = 1'b1;
				cmd.rd     = 1'b1;
				cmd.sel    = vpg_pkg::RD_BG;
				state_n    = vpg_pkg::ST_BITS;
			end
			vpg_pkg::ST_BITS: begin
				cmd.lat_bg = 1'b1;
				cmd.rd     = 1'b1;
				cmd.sel    = vpg_pkg::RD_BITS;
				state_n    = vpg_pkg::ST_PAL;
			end
			vpg_pkg::ST_PAL: begin
				if (border_q) cmd.lat_pal = 1'b1;
				else cmd.lat_bits = 1'b1;
				state_n = vpg_pkg::ST_OUT;
			end
			vpg_pkg::ST_OUT: begin
				if (!out_busy) begin
					cmd.out_set = 1'b1;
					state_n     = vpg_pkg::ST_IDLE;
				end
			end
			default: state_n = vpg_pkg::ST_IDLE;
		endcase
	end
endmodule

>>> hw/rtl/vpg_datapath.sv
// Datapath of the video pixel generator: config registers, video memory,
// address generation, blink counter and colour output. Depends on vpg_pkg.
module vpg_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [22:0]     cfg_data,
	input  logic [15:0]     address,
	input  logic [15:0]     data,
	input  logic [7:0]      pixel_x,
	input  logic [7:0]      pixel_y,
	input  vpg_pkg::cmd_t   cmd,
	output vpg_pkg::sts_t   sts,
	output logic [31:0]     rgba,
	output logic            drawn
);
	logic [2:0]  mode_q;
	logic [15:0] bp_q, at_q, pl_q, fn_q;
	logic [4:0]  bord_q;
	logic [22:0] half_q;
	logic [23:0] blink_q;

	logic [7:0]  x_q, y_q;
	logic [15:0] attr_q, fg_q, bg_q, rd_q;
	logic [7:0]  ch_q;
	logic        on_q;

	logic [15:0] mem [vpg_pkg::MEM_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; bp_q <= '0; at_q <= '0; pl_q <= '0;
			fn_q <= '0; bord_q <= '0; half_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vpg_pkg::REG_MODE:   mode_q <= cfg_data[2:0];
				vpg_pkg::REG_BPBASE: bp_q   <= cfg_data[15:0];
				vpg_pkg::REG_ATBASE: at_q   <= cfg_data[15:0];
				vpg_pkg::REG_PLBASE: pl_q   <= cfg_data[15:0];
				vpg_pkg::REG_FNBASE: fn_q   <= cfg_data[15:0];
				vpg_pkg::REG_BORDER: bord_q <= cfg_data[4:0];
				vpg_pkg::REG_BLINK:  half_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic        text;
	logic [4:0]  r_row;
	logic [23:0] lim, binc;
	assign text = (mode_q == vpg_pkg::MODE_TEXT4) || (mode_q == vpg_pkg::MODE_TEXT8);
	assign sts.text = text;
	assign sts.op_valid = (bp_q != '0) && (at_q != '0) && (mode_q <= vpg_pkg::MODE_TEXT8);
	assign lim  = {half_q, 1'b0};
	assign binc = blink_q + 24'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) blink_q <= '0;
		else if (cmd.tick) blink_q <= (binc > lim) ? binc - lim : binc;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= pixel_x; y_q <= pixel_y;
		end
	end

	// address generation
	logic [15:0] apos, tpos, cpos, raddr, bitaddr;
	logic [7:0]  col;
	always_comb begin
		col  = (mode_q == vpg_pkg::MODE_TEXT4) ? {2'b0, x_q[7:2]} : {3'b0, x_q[7:3]};
		unique case (mode_q)
			vpg_pkg::MODE_BMP4X8: apos = {5'b0, y_q[7:3], x_q[7:2]};
			vpg_pkg::MODE_BMP8X8: apos = {6'b0, y_q[7:3], x_q[7:3]};
			vpg_pkg::MODE_BMP8X2: apos = {4'b0, y_q[7:1], x_q[7:3]};
			default:              apos = '0;
		endcase
		// text: row*cols + col, and half of it for the char word
		tpos = (mode_q == vpg_pkg::MODE_TEXT4) ? {5'b0, y_q[7:3], col[5:0]}
			: {6'b0, y_q[7:3], col[4:0]};
		cpos = (mode_q == vpg_pkg::MODE_TEXT4) ? {6'b0, y_q[7:3], col[5:1]}
			: {7'b0, y_q[7:3], col[4:1]};
		unique case (mode_q)
			vpg_pkg::MODE_BMP2C: bitaddr = bp_q + {4'b0, y_q, x_q[7:4]};
			vpg_pkg::MODE_TEXT4: bitaddr = fn_q + {7'b0, ch_q, 1'b0} + {15'b0, x_q[1]};
			vpg_pkg::MODE_TEXT8: bitaddr = fn_q + {6'b0, ch_q, 2'b0} + {14'b0, y_q[2:1]};
			default:             bitaddr = bp_q + {4'b0, y_q, x_q[7:4]};
		endcase
		// the attribute word is still in the read register when fg is fetched
		unique case (cmd.sel)
			vpg_pkg::RD_ATTR:   raddr = at_q + (text ? tpos : apos);
			vpg_pkg::RD_CHAR:   raddr = bp_q + cpos;
			vpg_pkg::RD_FG:     raddr = pl_q + {10'b0, rd_q[11:6]};
			vpg_pkg::RD_BG:     raddr = pl_q + {10'b0, attr_q[5:0]};
			vpg_pkg::RD_BITS:   raddr = bitaddr;
			default:            raddr = pl_q + {11'b0, bord_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) mem[address[vpg_pkg::AW-1:0]] <= data;
		if (cmd.rd) rd_q <= mem[raddr[vpg_pkg::AW-1:0]];
	end

	// pixel bit from the fetched word
	logic [3:0] sh;
	logic       bit_on;
	assign r_row = {2'b0, y_q[2:0]};
	always_comb begin
		unique case (mode_q)
			vpg_pkg::MODE_BMP2C: sh = x_q[3:0];
			vpg_pkg::MODE_TEXT4: sh = x_q[0] ? {1'b0, y_q[2:0]} : {1'b1, y_q[2:0]};
			vpg_pkg::MODE_TEXT8:
				sh = y_q[0] ? 4'd7 - {1'b0, x_q[2:0]} : 4'd15 - {1'b0, x_q[2:0]};
			default: sh = 4'd15 - x_q[3:0];
		endcase
		bit_on = rd_q[sh] || (text && (r_row == 5'd7) && attr_q[13]);
	end

	always_ff @(posedge clk) begin
		if (cmd.lat_char) ch_q <= col[0] ? rd_q[15:8] : rd_q[7:0];
		if (cmd.lat_attr) attr_q <= rd_q;
		if (cmd.lat_fg)   fg_q <= rd_q;
		if (cmd.lat_bg) begin
			bg_q <= rd_q;
			if (text && (blink_q > {1'b0, half_q}) && attr_q[12]) fg_q <= rd_q;
		end
		if (cmd.load)     on_q <= 1'b0;
		if (cmd.lat_bits) on_q <= bit_on;
		if (cmd.lat_pal) begin
			fg_q <= rd_q;
			on_q <= 1'b1;
		end
	end

	logic [15:0] c;
	assign c = on_q ? fg_q : bg_q;

	// a border request leaves on_q set, so it is drawn even with drawing off
	always_ff @(posedge clk) begin
		if (cmd.out_set) begin
			if (sts.op_valid || on_q) begin
				rgba  <= {c[14:10], 3'b0, c[9:5], 3'b0, c[4:0], 3'b0, 8'hFF};
				drawn <= 1'b1;
			end else begin
				rgba  <= '0;
				drawn <= 1'b0;
			end
		end
	end
endmodule

>>> hw/rtl/video_pixel_generator.sv
// Top level of the video pixel generator: stream ports, controller, datapath.
// Depends on vpg_pkg, vpg_ctrl, vpg_datapath.
// One request at a time, taken only in the idle state, where a memory write or
// tick is done. A border request goes through the attr, pal and out states, a
// render through attr and out (drawing off) or attr, fg, bg, bits, pal and out
// (bitmap modes), with char after attr (text modes), as set by the chain of
// dependent reads on the single video memory port (character, attribute, two
// palette words, bitmap or glyph word). The result waits in an output register
// until taken; the controller holds in out only while an earlier result waits.
module video_pixel_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // address[15:0], data[31:16], pixel_x[39:32], pixel_y[47:40]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // rgba[31:0]
	output logic        m_tuser,  // drawn
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data
);
	vpg_pkg::cmd_t cmd;
	vpg_pkg::sts_t sts;
	logic idle, in_fire, vld_q, out_busy;

	assign out_busy = vld_q && !m_tready;
	assign s_tready = idle;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (cmd.out_set) vld_q <= 1'b1;
		else if (m_tready) vld_q <= 1'b0;
	end
	assign m_tvalid = vld_q;

	vpg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .opcode(s_tuser),
		.out_busy(out_busy), .sts(sts), .idle(idle), .cmd(cmd)
	);

	vpg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .address(s_tdata[15:0]),
		.data(s_tdata[31:16]), .pixel_x(s_tdata[39:32]), .pixel_y(s_tdata[47:40]),
		.cmd(cmd), .sts(sts), .rgba(m_tdata), .drawn(m_tuser)
	);
endmodule

>>> sim/vpg_checker.sv
// Checker for the video pixel generator: watches request, result and config traffic,
// keeps its own copy of video memory, registers and blink counter, and compares results.
// Depends on vpg_pkg.
module vpg_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          pixels_seen,
	output int          pixels_drawn
);
	typedef struct packed {
		logic [31:0] rgba;
		logic        drawn;
	} pixel_t;

	logic [15:0]  vmem [0:vpg_pkg::MEM_WORDS-1];
	int unsigned  mode, bp_base, at_base, pl_base, fn_base, border_idx, blink_half;
	int unsigned  blink_cnt;
	pixel_t       pixel_q[$];

	function automatic int unsigned mem_rd(int unsigned a);
		return vmem[(a & 32'hFFFF) % vpg_pkg::MEM_WORDS];
	endfunction

	function automatic logic [31:0] rgb555_to_rgba(int unsigned c);
		return {c[14:10], 3'b0, c[9:5], 3'b0, c[4:0], 3'b0, 8'hFF};
	endfunction

	function automatic pixel_t shade_pixel(int unsigned x, int unsigned y);
		int unsigned attr, fgc, bgc, w, on, apos, row, r, cols, col, cw, ch, cx;
		pixel_t px;
		px = '0;
		if (bp_base == 0 || at_base == 0 || mode > vpg_pkg::MODE_TEXT8)
			return px;
		px.drawn = 1'b1;
		if (mode <= vpg_pkg::MODE_BMP2C) begin
			case (mode)
				vpg_pkg::MODE_BMP4X8: apos = (y / 8) * 64 + x / 4;
				vpg_pkg::MODE_BMP8X8: apos = (y / 8) * 32 + x / 8;
				vpg_pkg::MODE_BMP8X2: apos = (y / 2) * 32 + x / 8;
				default: apos = 0;
			endcase
			attr = mem_rd(at_base + apos);
			fgc = mem_rd(pl_base + ((attr & 16'h0FC0) >> 6));
			bgc = mem_rd(pl_base + (attr & 16'h003F));
			if (mode == vpg_pkg::MODE_BMP2C) begin
				w = mem_rd(bp_base + y * 16 + x / 16);
				on = (w >> (x & 15)) & 1;
			end else begin
				w = mem_rd(bp_base + ((y * 256 + x) >> 4));
				on = (w >> (15 - (x & 15))) & 1;
			end
		end else begin
			row = y / 8;
			r = y & 7;
			cols = (mode == vpg_pkg::MODE_TEXT4) ? 64 : 32;
			col = (mode == vpg_pkg::MODE_TEXT4) ? x / 4 : x / 8;
			cw = mem_rd(bp_base + (row * cols) / 2 + col / 2);
			ch = (col & 1) ? ((cw >> 8) & 8'hFF) : (cw & 8'hFF);
			attr = mem_rd(at_base + row * cols + col);
			fgc = mem_rd(pl_base + ((attr & 16'h0FC0) >> 6));
			bgc = mem_rd(pl_base + (attr & 16'h003F));
			if (blink_cnt > blink_half && attr[12])
				fgc = bgc;
			if (mode == vpg_pkg::MODE_TEXT4) begin
				cx = x & 3;
				w = mem_rd(fn_base + ch * 2 + (cx >> 1));
				on = (w >> ((cx & 1) ? r : r + 8)) & 1;
			end else begin
				cx = x & 7;
				w = mem_rd(fn_base + ch * 4 + (r >> 1));
				on = (w >> ((r & 1) ? 7 - cx : 15 - cx)) & 1;
			end
			// underline forces the bottom glyph row on
			if (r == 7 && attr[13])
				on = 1;
		end
		px.rgba = rgb555_to_rgba(on ? fgc : bgc);
		return px;
	endfunction

	assign pending = pixel_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t       want;
		int unsigned  lim, nxt;
		if (!arst_n) begin
			mode <= 0; bp_base <= 0; at_base <= 0; pl_base <= 0; fn_base <= 0;
			border_idx <= 0; blink_half <= 0; blink_cnt <= 0;
			errors <= 0; pixels_seen <= 0; pixels_drawn <= 0;
			pixel_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					vpg_pkg::REG_MODE:   mode       <= 32'(cfg_data[2:0]);
					vpg_pkg::REG_BPBASE: bp_base    <= 32'(cfg_data[15:0]);
					vpg_pkg::REG_ATBASE: at_base    <= 32'(cfg_data[15:0]);
					vpg_pkg::REG_PLBASE: pl_base    <= 32'(cfg_data[15:0]);
					vpg_pkg::REG_FNBASE: fn_base    <= 32'(cfg_data[15:0]);
					vpg_pkg::REG_BORDER: border_idx <= 32'(cfg_data[4:0]);
					vpg_pkg::REG_BLINK:  blink_half <= 32'(cfg_data[22:0]);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					vpg_pkg::OP_WRITE:
						vmem[s_tdata[15:0] % vpg_pkg::MEM_WORDS] <= s_tdata[31:16];
					vpg_pkg::OP_TICK: begin
						lim = blink_half << 1;
						nxt = (blink_cnt + 1) & 24'hFFFFFF;
						if (nxt > lim)
							nxt = (nxt - lim) & 24'hFFFFFF;
						blink_cnt <= nxt;
					end
					vpg_pkg::OP_BORDER:
						pixel_q.push_back({rgb555_to_rgba(mem_rd(pl_base + border_idx)), 1'b1});
					default: pixel_q.push_back(shade_pixel(s_tdata[39:32], s_tdata[47:40]));
				endcase
			end
			if (m_tvalid && m_tready) begin
				pixels_seen <= pixels_seen + 1;
				if (m_tuser)
					pixels_drawn <= pixels_drawn + 1;
				if (pixel_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result rgba=%h drawn=%b", m_tdata, m_tuser);
					errors <= errors + 1;
				end else begin
					want = pixel_q.pop_front();
					if (want.rgba !== m_tdata || want.drawn !== m_tuser) begin
						if (errors < 10)
							$display("mismatch: rgba exp %h got %h, drawn exp %b got %b",
								want.rgba, m_tdata, want.drawn, m_tuser);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

>>> sim/tb_top.sv
// Testbench top for the video pixel generator: clock, reset, request and config stimulus.
// Depends on vpg_pkg, video_pixel_generator and vpg_checker.
module tb_top;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = vpg_pkg::OP_WRITE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = vpg_pkg::REG_MODE;
	logic [22:0] cfg_data = '0;
	int          errors, pending, pixels_seen, pixels_drawn;
	int          idle_pct = 0, stall_pct = 0, phase_no = 0;
	int          hold_left = 0;
	bit          hold_done = 0;
	int          sent = 0;

	// words already written, so that every read the block makes hits written memory
	logic [15:0] shadow [vpg_pkg::MEM_WORDS];
	bit          written [vpg_pkg::MEM_WORDS];
	logic [22:0] reg_val [8];

	video_pixel_generator dut (.*);
	vpg_checker u_chk (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver side; one long hold-off in phase 5 so the block backs up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (phase_no == 5 && !hold_done) begin
			hold_done <= 1;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(logic [1:0] op, logic [15:0] addr, logic [15:0] wdata,
			logic [7:0] x, logic [7:0] y);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {y, x, wdata, addr};
		if (op == vpg_pkg::OP_WRITE) begin
			shadow[addr[vpg_pkg::AW-1:0]] = wdata;
			written[addr[vpg_pkg::AW-1:0]] = 1'b1;
		end
		sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic touch(logic [15:0] a);
		if (!written[a[vpg_pkg::AW-1:0]])
			send(vpg_pkg::OP_WRITE, a, 16'($urandom), 8'd0, 8'd0);
	endtask

	// writes any word the render will read that is not yet written, then sends the render
	task automatic render_px(logic [7:0] x, logic [7:0] y);
		logic [2:0]  mode;
		logic [15:0] bp, at, pl, fn, a, attr, cw;
		logic [7:0]  ch;
		int unsigned xi, yi, apos, cols, col;
		mode = reg_val[vpg_pkg::REG_MODE][2:0];
		bp = reg_val[vpg_pkg::REG_BPBASE][15:0];
		at = reg_val[vpg_pkg::REG_ATBASE][15:0];
		pl = reg_val[vpg_pkg::REG_PLBASE][15:0];
		fn = reg_val[vpg_pkg::REG_FNBASE][15:0];
		xi = 32'(x);
		yi = 32'(y);
		if (bp != '0 && at != '0 && mode <= vpg_pkg::MODE_TEXT8) begin
			if (mode <= vpg_pkg::MODE_BMP2C) begin
				case (mode)
					vpg_pkg::MODE_BMP4X8: apos = (yi / 8) * 64 + xi / 4;
					vpg_pkg::MODE_BMP8X8: apos = (yi / 8) * 32 + xi / 8;
					vpg_pkg::MODE_BMP8X2: apos = (yi / 2) * 32 + xi / 8;
					default: apos = 0;
				endcase
				a = 16'(at + apos);
				touch(a);
				attr = shadow[a[vpg_pkg::AW-1:0]];
				touch(16'(pl + attr[11:6]));
				touch(16'(pl + attr[5:0]));
				touch(16'(bp + yi * 16 + xi / 16));
			end else begin
				cols = (mode == vpg_pkg::MODE_TEXT4) ? 64 : 32;
				col = (mode == vpg_pkg::MODE_TEXT4) ? xi / 4 : xi / 8;
				a = 16'(bp + ((yi / 8) * cols) / 2 + col / 2);
				touch(a);
				cw = shadow[a[vpg_pkg::AW-1:0]];
				ch = col[0] ? cw[15:8] : cw[7:0];
				a = 16'(at + (yi / 8) * cols + col);
				touch(a);
				attr = shadow[a[vpg_pkg::AW-1:0]];
				touch(16'(pl + attr[11:6]));
				touch(16'(pl + attr[5:0]));
				if (mode == vpg_pkg::MODE_TEXT4)
					touch(16'(fn + ch * 2 + ((xi & 3) >> 1)));
				else
					touch(16'(fn + ch * 4 + ((yi & 7) >> 1)));
			end
		end
		send(vpg_pkg::OP_RENDER, 16'($urandom), 16'($urandom), x, y);
	endtask

	task automatic border_px();
		touch(16'(reg_val[vpg_pkg::REG_PLBASE][15:0] + reg_val[vpg_pkg::REG_BORDER][4:0]));
		send(vpg_pkg::OP_BORDER, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [22:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		reg_val[idx] = val;
		@(posedge clk);
	endtask

	task automatic random_request();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			render_px(8'($urandom), ($urandom_range(9) == 0) ?
				8'($urandom_range(192, 255)) : 8'($urandom_range(191)));
		else if (pick < 80)
			send(vpg_pkg::OP_WRITE, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
		else if (pick < 92)
			send(vpg_pkg::OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
		else
			border_px();
	endtask

	initial begin
		logic [22:0] blink_val;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 16; p++) begin
			drain();
			phase_no <= p;
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			case (p % 3)
				0: blink_val = 23'($urandom_range(1, 4));
				1: blink_val = (p == 1) ? 23'h7FFFFF : 23'd0;
				default: blink_val = 23'($urandom_range(0, 2));
			endcase
			set_reg(vpg_pkg::REG_MODE, (p < 8) ? 23'(p) : 23'($urandom_range(5)));
			set_reg(vpg_pkg::REG_BPBASE, (p == 8) ? 23'h0 : (p == 9) ? 23'hFFFF :
				23'($urandom_range(1, 16'hFFFF)));
			set_reg(vpg_pkg::REG_ATBASE, (p == 10) ? 23'h0 : (p == 11) ? 23'hFFFF :
				23'($urandom_range(1, 16'hFFFF)));
			set_reg(vpg_pkg::REG_PLBASE, (p == 3) ? 23'hFFF0 : (p == 12) ? 23'h0 :
				23'($urandom_range(16'hFFFF)));
			set_reg(vpg_pkg::REG_FNBASE, (p == 4) ? 23'hFFFF : (p == 13) ? 23'h0 :
				23'($urandom_range(16'hFFFF)));
			set_reg(vpg_pkg::REG_BORDER, (p == 0) ? 23'd31 : (p == 1) ? 23'd0 :
				23'($urandom_range(31)));
			set_reg(vpg_pkg::REG_BLINK, blink_val);
			cfg_we <= 1'b0;
			if (p < 6 || p == 8) begin
				// corners of the screen, rows past the visible area, underline row
				render_px(8'd0, 8'd0);
				render_px(8'd255, 8'd191);
				render_px(8'd255, 8'd255);
				render_px(8'd3, 8'd7);
				border_px();
				send(vpg_pkg::OP_TICK, 16'h0, 16'h0, 8'd0, 8'd0);
			end
			while (sent < (p + 1) * 106)
				random_request();
		end
		drain();
		$display("%0d requests sent, %0d pixel results checked (%0d drawn) over 16 settings",
			sent, pixels_seen, pixels_drawn);
		$display("all six modes and off, blink, underline, wrapped bases and a long output hold-off");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

>>> video_pixel_generator.f
hw/rtl/vpg_pkg.sv
hw/rtl/vpg_ctrl.sv
hw/rtl/vpg_datapath.sv
hw/rtl/video_pixel_generator.sv
sim/vpg_checker.sv
sim/tb_top.sv
